FILE: sv/ftp_pkg.sv
package ftp_pkg;

   localparam int unsigned TIME_W   = 63;
   localparam int unsigned DELTA_W  = 32;
   localparam int unsigned RATE_W   = 16;
   localparam int unsigned WIN_W    = 33;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned REQ_DATA_W = 64;
   localparam int unsigned RSP_DATA_W = 112;

   localparam logic [DELTA_W-1:0] TPS_RESET       = 32'd1000;
   localparam logic [DELTA_W-1:0] MAX_DELTA_RESET = 32'd250;

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [WIN_W-1:0]  WIN_MAX  = {WIN_W{1'b1}};
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   localparam logic [CSR_IDX_W-1:0] REG_TICKS_PER_SECOND = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_DELTA_TICKS  = 2'd1;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_START = 2'd1,
      CMD_STOP  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   // state snapshot after one command, enough to form the result word
   typedef struct packed {
      logic [DELTA_W-1:0] delta_ticks;
      logic [RATE_W-1:0]  frame_rate;
      logic               is_stopped;
      logic [TIME_W-1:0]  ref_time;
      logic [TIME_W-1:0]  base_time;
      logic [TIME_W-1:0]  paused_total;
   } snap_type;

endpackage

FILE: sv/ftp_core.sv
module ftp_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   input  ftp_pkg::cmd_type                cmd,
   input  logic [ftp_pkg::TIME_W-1:0]      now,
   input  logic [ftp_pkg::DELTA_W-1:0]     ticks_per_second,
   input  logic [ftp_pkg::DELTA_W-1:0]     max_delta_ticks,
   input  logic                            snap_take,
   output logic                            item_ready,
   output logic                            snap_valid,
   output ftp_pkg::snap_type               snap
);

   logic [ftp_pkg::TIME_W-1:0]  base_ff, base_in;
   logic [ftp_pkg::TIME_W-1:0]  paused_ff, paused_in;
   logic [ftp_pkg::TIME_W-1:0]  stop_ff, stop_in;
   logic [ftp_pkg::TIME_W-1:0]  last_ff, last_in;
   logic [ftp_pkg::TIME_W-1:0]  cur_ff, cur_in;
   logic [ftp_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic [ftp_pkg::WIN_W-1:0]   win_ff, win_in;
   logic [ftp_pkg::RATE_W-1:0]  fcount_ff, fcount_in;
   logic [ftp_pkg::RATE_W-1:0]  rate_ff, rate_in;
   logic                        stopped_ff, stopped_in;
   logic                        snap_valid_ff, snap_valid_in;
   ftp_pkg::snap_type           snap_ff, snap_in;

   logic                        advance;
   logic [ftp_pkg::TIME_W:0]    tick_diff;
   logic [ftp_pkg::TIME_W-1:0]  tick_span;
   logic [ftp_pkg::DELTA_W-1:0] tick_delta;
   logic [ftp_pkg::RATE_W-1:0]  fcount_inc;
   logic [ftp_pkg::WIN_W:0]     win_sum;
   logic [ftp_pkg::WIN_W-1:0]   win_sat;
   logic [ftp_pkg::TIME_W:0]    start_diff;
   logic [ftp_pkg::TIME_W:0]    paused_sum;

   assign advance    = item_valid && (!snap_valid_ff || snap_take);
   assign item_ready = advance;

   // frame delta, floored at zero and clamped
   always_comb begin
      tick_diff = {1'b0, now} - {1'b0, last_ff};
      if (!tick_diff[ftp_pkg::TIME_W] && (tick_diff != '0)) begin
         tick_span = tick_diff[ftp_pkg::TIME_W-1:0];
      end else begin
         tick_span = '0;
      end
      if (tick_span > {{(ftp_pkg::TIME_W-ftp_pkg::DELTA_W){1'b0}}, max_delta_ticks}) begin
         tick_delta = max_delta_ticks;
      end else begin
         tick_delta = tick_span[ftp_pkg::DELTA_W-1:0];
      end
      fcount_inc = (fcount_ff != ftp_pkg::RATE_MAX) ? fcount_ff + 1'b1 : fcount_ff;
      win_sum = {1'b0, win_ff} + {{(ftp_pkg::WIN_W+1-ftp_pkg::DELTA_W){1'b0}}, tick_delta};
      win_sat = win_sum[ftp_pkg::WIN_W] ? ftp_pkg::WIN_MAX : win_sum[ftp_pkg::WIN_W-1:0];
      start_diff = {1'b0, now} - {1'b0, stop_ff};
      paused_sum = {1'b0, paused_ff} + start_diff;
   end

   always_comb begin
      base_in    = base_ff;
      paused_in  = paused_ff;
      stop_in    = stop_ff;
      last_in    = last_ff;
      cur_in     = cur_ff;
      delta_in   = delta_ff;
      win_in     = win_ff;
      fcount_in  = fcount_ff;
      rate_in    = rate_ff;
      stopped_in = stopped_ff;
      case (cmd)
         ftp_pkg::CMD_TICK: begin
            if (stopped_ff) begin
               delta_in = '0;
            end else begin
               cur_in    = now;
               last_in   = now;
               delta_in  = tick_delta;
               fcount_in = fcount_inc;
               win_in    = win_sat;
               if (win_sat >= {1'b0, ticks_per_second}) begin
                  rate_in   = fcount_inc;
                  fcount_in = '0;
                  win_in    = win_sat - {1'b0, ticks_per_second};
               end
            end
         end
         ftp_pkg::CMD_START: begin
            if (stopped_ff) begin
               if (!start_diff[ftp_pkg::TIME_W] && (start_diff != '0)) begin
                  // start_diff is below 2^63 here, so the sum fits in 64 bits
                  paused_in = paused_sum[ftp_pkg::TIME_W] ? ftp_pkg::TIME_MAX
                                                          : paused_sum[ftp_pkg::TIME_W-1:0];
               end
               last_in    = now;
               stop_in    = '0;
               stopped_in = 1'b0;
            end
         end
         ftp_pkg::CMD_STOP: begin
            if (!stopped_ff) begin
               stop_in    = now;
               stopped_in = 1'b1;
            end
         end
         ftp_pkg::CMD_RESET: begin
            base_in    = now;
            paused_in  = '0;
            stop_in    = '0;
            cur_in     = now;
            last_in    = now;
            delta_in   = '0;
            win_in     = '0;
            fcount_in  = '0;
            rate_in    = '0;
            stopped_in = 1'b0;
         end
         default: begin
            stopped_in = stopped_ff;
         end
      endcase
   end

   always_comb begin
      snap_in.delta_ticks  = delta_in;
      snap_in.frame_rate   = rate_in;
      snap_in.is_stopped   = stopped_in;
      snap_in.ref_time     = stopped_in ? stop_in : cur_in;
      snap_in.base_time    = base_in;
      snap_in.paused_total = paused_in;
   end

   always_comb begin
      if (advance) begin
         snap_valid_in = 1'b1;
      end else if (snap_take) begin
         snap_valid_in = 1'b0;
      end else begin
         snap_valid_in = snap_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff       <= '0;
         paused_ff     <= '0;
         stop_ff       <= '0;
         last_ff       <= '0;
         cur_ff        <= '0;
         delta_ff      <= '0;
         win_ff        <= '0;
         fcount_ff     <= '0;
         rate_ff       <= '0;
         stopped_ff    <= 1'b0;
         snap_valid_ff <= 1'b0;
      end else begin
         snap_valid_ff <= snap_valid_in;
         if (advance) begin
            base_ff    <= base_in;
            paused_ff  <= paused_in;
            stop_ff    <= stop_in;
            last_ff    <= last_in;
            cur_ff     <= cur_in;
            delta_ff   <= delta_in;
            win_ff     <= win_in;
            fcount_ff  <= fcount_in;
            rate_ff    <= rate_in;
            stopped_ff <= stopped_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         snap_ff <= snap_in;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;

endmodule

FILE: sv/ftp_total.sv
module ftp_total (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                snap_valid,
   input  ftp_pkg::snap_type                   snap,
   output logic                                snap_take,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ftp_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic                              out_valid_ff, out_valid_in;
   logic [ftp_pkg::RSP_DATA_W-1:0]    out_data_ff, out_data_in;
   logic                              load;
   logic signed [ftp_pkg::TIME_W+2:0] run_span;
   logic [ftp_pkg::TIME_W-1:0]        total;

   assign snap_take = !out_valid_ff || rsp_tready;
   assign load      = snap_valid && snap_take;

   // ref - base - paused; positive only when both floors pass
   always_comb begin
      run_span = $signed({3'b000, snap.ref_time})
               - $signed({3'b000, snap.base_time})
               - $signed({3'b000, snap.paused_total});
      if (!run_span[ftp_pkg::TIME_W+2] && (run_span != '0)) begin
         total = run_span[ftp_pkg::TIME_W-1:0];
      end else begin
         total = '0;
      end
      out_data_in = {snap.is_stopped, total, snap.frame_rate, snap.delta_ticks};
   end

   always_comb begin
      if (load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

FILE: sv/frame_timer_with_pause.sv
// path: an accepted req word passes the input register, the state update and the total and
// result register in that order, and a stalled rsp side can hold it between any of them
// throughput: one word per cycle while rsp_tready does not stall the result side
// reset: synchronous, active high; clears all timer state to running at time 0,
// empties the pipeline and loads ticks_per_second 1000 and max_delta_ticks 250
module frame_timer_with_pause (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ftp_pkg::REQ_DATA_W-1:0]      req_tdata,  // now[62:0], pad
   input  logic [1:0]                          req_tuser,  // cmd[1:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // delta_ticks[31:0], frame_rate[47:32], total_ticks[110:48], is_stopped[111]
   output logic [ftp_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ftp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ftp_pkg::DELTA_W-1:0]         csr_data
);

   logic                        in_valid_ff, in_valid_in;
   ftp_pkg::cmd_type            cmd_ff;
   logic [ftp_pkg::TIME_W-1:0]  now_ff;
   logic [ftp_pkg::DELTA_W-1:0] tps_ff, tps_in;
   logic [ftp_pkg::DELTA_W-1:0] max_delta_ff, max_delta_in;
   logic                        item_ready;
   logic                        snap_valid;
   logic                        snap_take;
   ftp_pkg::snap_type           snap;
   logic                        req_take;

   assign req_tready = !in_valid_ff || item_ready;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (item_ready) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      tps_in       = tps_ff;
      max_delta_in = max_delta_ff;
      if (csr_valid) begin
         case (csr_index)
            ftp_pkg::REG_TICKS_PER_SECOND: tps_in       = csr_data;
            ftp_pkg::REG_MAX_DELTA_TICKS:  max_delta_in = csr_data;
            default:                       tps_in       = tps_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         tps_ff       <= ftp_pkg::TPS_RESET;
         max_delta_ff <= ftp_pkg::MAX_DELTA_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         tps_ff       <= tps_in;
         max_delta_ff <= max_delta_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff <= ftp_pkg::cmd_type'(req_tuser);
         now_ff <= req_tdata[ftp_pkg::TIME_W-1:0];
      end
   end

   ftp_core u_core (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (in_valid_ff),
      .cmd              (cmd_ff),
      .now              (now_ff),
      .ticks_per_second (tps_ff),
      .max_delta_ticks  (max_delta_ff),
      .snap_take        (snap_take),
      .item_ready       (item_ready),
      .snap_valid       (snap_valid),
      .snap             (snap)
   );

   ftp_total u_total (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (snap_valid),
      .snap       (snap),
      .snap_take  (snap_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sv/ftp_checker.sv
module ftp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ftp_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   // nothing left in flight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // with the result side empty the whole pipeline drains, so input is open
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low while no result is pending");

   // a new result rises only after its word has passed all three register stages
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready, 3))
      else $error("result appeared without a word accepted three edges before");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

endmodule

bind frame_timer_with_pause ftp_checker u_ftp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: test/frame_timer_checker.sv
module frame_timer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ftp_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                     req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ftp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [ftp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ftp_pkg::DELTA_W-1:0]    csr_data,
   output int unsigned                    mismatches,
   output int unsigned                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [ftp_pkg::DELTA_W-1:0] delta_ticks;
      logic [ftp_pkg::RATE_W-1:0]  frame_rate;
      logic [ftp_pkg::TIME_W-1:0]  total_ticks;
      logic                        is_stopped;
   } frame_status_type;

   // timer configuration
   logic [ftp_pkg::DELTA_W-1:0] ticks_per_second;
   logic [ftp_pkg::DELTA_W-1:0] max_delta;

   // timer state
   logic [ftp_pkg::TIME_W-1:0]  base_time;
   logic [ftp_pkg::TIME_W-1:0]  paused_total;
   logic [ftp_pkg::TIME_W-1:0]  stop_time;
   logic [ftp_pkg::TIME_W-1:0]  last_time;
   logic [ftp_pkg::TIME_W-1:0]  current_time;
   logic [ftp_pkg::DELTA_W-1:0] last_delta;
   logic [ftp_pkg::WIN_W-1:0]   window_accum;
   logic [ftp_pkg::RATE_W-1:0]  frame_count;
   logic [ftp_pkg::RATE_W-1:0]  latched_rate;
   logic                        stopped;

   frame_status_type status_q[$];
   int unsigned      fail_count = 0;
   int unsigned      queued = 0;

   assign mismatches = fail_count;
   assign pending    = queued;

   function automatic void restart_timer(input logic [ftp_pkg::TIME_W-1:0] t);
      base_time    = t;
      paused_total = '0;
      stop_time    = '0;
      current_time = t;
      last_time    = t;
      last_delta   = '0;
      window_accum = '0;
      frame_count  = '0;
      latched_rate = '0;
      stopped      = 1'b0;
   endfunction

   function automatic void count_frame(input logic [ftp_pkg::TIME_W-1:0] t);
      logic [ftp_pkg::TIME_W-1:0] d;
      logic [ftp_pkg::TIME_W-1:0] clamp;
      logic [ftp_pkg::WIN_W:0]    sum;
      if (stopped) begin
         last_delta = '0;
         return;
      end
      current_time = t;
      d = (t > last_time) ? t - last_time : '0;
      last_time = t;
      clamp = {{(ftp_pkg::TIME_W-ftp_pkg::DELTA_W){1'b0}}, max_delta};
      if (d > clamp) begin
         d = clamp;
      end
      last_delta = d[ftp_pkg::DELTA_W-1:0];
      if (frame_count != ftp_pkg::RATE_MAX) begin
         frame_count = frame_count + 1'b1;
      end
      sum = {1'b0, window_accum} + {2'b0, last_delta};
      window_accum = (sum > {1'b0, ftp_pkg::WIN_MAX}) ? ftp_pkg::WIN_MAX
                                                      : sum[ftp_pkg::WIN_W-1:0];
      if (window_accum >= {1'b0, ticks_per_second}) begin
         latched_rate = frame_count;
         frame_count  = '0;
         window_accum = window_accum - {1'b0, ticks_per_second};
      end
   endfunction

   function automatic void apply_command(input ftp_pkg::cmd_type op,
                                         input logic [ftp_pkg::TIME_W-1:0] t);
      logic [ftp_pkg::TIME_W-1:0] span;
      case (op)
         ftp_pkg::CMD_TICK: begin
            count_frame(t);
         end
         ftp_pkg::CMD_START: begin
            if (stopped) begin
               if (t > stop_time) begin
                  span = t - stop_time;
                  // paused sum saturates instead of wrapping
                  if (span > ftp_pkg::TIME_MAX - paused_total) begin
                     paused_total = ftp_pkg::TIME_MAX;
                  end else begin
                     paused_total = paused_total + span;
                  end
               end
               last_time = t;
               stop_time = '0;
               stopped   = 1'b0;
            end
         end
         ftp_pkg::CMD_STOP: begin
            if (!stopped) begin
               stop_time = t;
               stopped   = 1'b1;
            end
         end
         default: begin
            restart_timer(t);
         end
      endcase
   endfunction

   function automatic frame_status_type timer_status();
      frame_status_type           s;
      logic [ftp_pkg::TIME_W-1:0] ref_t;
      logic [ftp_pkg::TIME_W-1:0] span;
      s.delta_ticks = last_delta;
      s.frame_rate  = latched_rate;
      s.is_stopped  = stopped;
      ref_t = stopped ? stop_time : current_time;
      span  = ref_t - base_time;
      if (ref_t <= base_time || span <= paused_total) begin
         s.total_ticks = '0;
      end else begin
         s.total_ticks = span - paused_total;
      end
      return s;
   endfunction

   function automatic void check_field(input string label, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, label, want, got);
      end
   endfunction

   always @(posedge clock) begin
      frame_status_type want;
      frame_status_type got;
      if (reset) begin
         ticks_per_second = ftp_pkg::TPS_RESET;
         max_delta        = ftp_pkg::MAX_DELTA_RESET;
         restart_timer('0);
         status_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ftp_pkg::REG_TICKS_PER_SECOND: ticks_per_second = csr_data;
               ftp_pkg::REG_MAX_DELTA_TICKS:  max_delta = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            apply_command(ftp_pkg::cmd_type'(req_tuser), req_tdata[ftp_pkg::TIME_W-1:0]);
            status_q.push_back(timer_status());
         end
         if (rsp_tvalid && rsp_tready) begin
            got.delta_ticks = rsp_tdata[31:0];
            got.frame_rate  = rsp_tdata[47:32];
            got.total_ticks = rsp_tdata[110:48];
            got.is_stopped  = rsp_tdata[111];
            if (status_q.size() == 0) begin
               fail_count++;
               $display("%0t: result word with nothing expected, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               want = status_q.pop_front();
               check_field("delta_ticks", 64'(want.delta_ticks), 64'(got.delta_ticks));
               check_field("frame_rate", 64'(want.frame_rate), 64'(got.frame_rate));
               check_field("total_ticks", 64'(want.total_ticks), 64'(got.total_ticks));
               check_field("is_stopped", 64'(want.is_stopped), 64'(got.is_stopped));
            end
         end
      end
      queued = status_q.size();
   end

endmodule

FILE: test/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes the block does not decode
   localparam logic [ftp_pkg::CSR_IDX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [ftp_pkg::CSR_IDX_W-1:0] REG_SPARE_B = 2'd3;
   localparam logic [ftp_pkg::DELTA_W-1:0]   REG_ALL_ONES = {ftp_pkg::DELTA_W{1'b1}};
   localparam int unsigned                   QUIET_LIMIT = 2000;
   localparam int unsigned                   SETTLE_CYCLES = 12;
   localparam int unsigned                   PHASE_WORDS = 250;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ftp_pkg::REQ_DATA_W-1:0] req_tdata;
   logic [1:0]                     req_tuser;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ftp_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid;
   logic                           csr_ready;
   logic [ftp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [ftp_pkg::DELTA_W-1:0]    csr_data;
   int unsigned                    mismatches;
   int unsigned                    pending;

   bit                             steady = 1'b0;   // no gaps on either side while set
   int unsigned                    quiet_cycles = 0;

   frame_timer_with_pause dut (.*);

   frame_timer_checker scoreboard (.*);

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("** frame_timer_with_pause: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stall before each word
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 5);
         if (stall != 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   function automatic logic [ftp_pkg::TIME_W-1:0] widen(input logic [31:0] v);
      return {{(ftp_pkg::TIME_W-32){1'b0}}, v};
   endfunction

   function automatic logic [ftp_pkg::TIME_W-1:0] random_stamp();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[ftp_pkg::TIME_W-1:0];
   endfunction

   task automatic send_command(input ftp_pkg::cmd_type op,
                               input logic [ftp_pkg::TIME_W-1:0] t);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = {1'b0, t};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // only while the timer has nothing in flight
   task automatic write_reg(input logic [ftp_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ftp_pkg::DELTA_W-1:0] value);
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_rates(input logic [ftp_pkg::DELTA_W-1:0] tps,
                            input logic [ftp_pkg::DELTA_W-1:0] clamp);
      write_reg(ftp_pkg::REG_TICKS_PER_SECOND, tps);
      write_reg(ftp_pkg::REG_MAX_DELTA_TICKS, clamp);
   endtask

   // mostly forward-running timelines with pauses, plus backward jumps and noise
   task automatic run_timeline(input int unsigned words, input int unsigned step_hi);
      logic [ftp_pkg::TIME_W-1:0] stamp;
      int unsigned                pick;
      stamp = widen($urandom_range(0, 1000));
      send_command(ftp_pkg::CMD_RESET, stamp);
      repeat (words) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) begin
            stamp = stamp + widen($urandom_range(0, step_hi));
            send_command(ftp_pkg::CMD_TICK, stamp);
         end else if (pick < 76) begin
            stamp = stamp + widen($urandom_range(0, step_hi));
            send_command(ftp_pkg::CMD_STOP, stamp);
         end else if (pick < 84) begin
            stamp = stamp + widen($urandom_range(0, step_hi))
                  + widen($urandom_range(0, step_hi));
            send_command(ftp_pkg::CMD_START, stamp);
         end else if (pick < 90) begin
            stamp = stamp - widen($urandom_range(0, step_hi));
            send_command(ftp_pkg::cmd_type'($urandom_range(0, 2)), stamp);
         end else if (pick < 94) begin
            send_command(ftp_pkg::CMD_RESET, stamp);
         end else begin
            stamp = random_stamp();
            send_command(ftp_pkg::cmd_type'($urandom_range(0, 3)), stamp);
         end
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = ftp_pkg::CMD_TICK;
      csr_valid  = 1'b0;
      csr_index  = ftp_pkg::REG_TICKS_PER_SECOND;
      csr_data   = '0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // reset configuration: clamp, backward sample, redundant stop and start
      send_command(ftp_pkg::CMD_TICK, 63'd0);
      send_command(ftp_pkg::CMD_TICK, 63'd100);
      send_command(ftp_pkg::CMD_TICK, 63'd1000);
      send_command(ftp_pkg::CMD_TICK, 63'd500);
      send_command(ftp_pkg::CMD_STOP, 63'd600);
      send_command(ftp_pkg::CMD_STOP, 63'd700);
      send_command(ftp_pkg::CMD_TICK, 63'd800);
      send_command(ftp_pkg::CMD_START, 63'd500);
      send_command(ftp_pkg::CMD_START, 63'd900);
      send_command(ftp_pkg::CMD_STOP, 63'd1000);
      send_command(ftp_pkg::CMD_START, 63'd2000);
      send_command(ftp_pkg::CMD_TICK, 63'd2100);
      send_command(ftp_pkg::CMD_TICK, 63'd2400);
      send_command(ftp_pkg::CMD_RESET, ftp_pkg::TIME_MAX);
      send_command(ftp_pkg::CMD_TICK, 63'd0);
      // paused sum saturation
      send_command(ftp_pkg::CMD_RESET, 63'd0);
      send_command(ftp_pkg::CMD_STOP, 63'd0);
      send_command(ftp_pkg::CMD_START, ftp_pkg::TIME_MAX);
      send_command(ftp_pkg::CMD_STOP, 63'd5);
      send_command(ftp_pkg::CMD_START, 63'd100);
      send_command(ftp_pkg::CMD_TICK, ftp_pkg::TIME_MAX);

      // zero window and zero clamp, then writes to undecoded indexes
      set_rates('0, '0);
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
      send_command(ftp_pkg::CMD_RESET, 63'd0);
      send_command(ftp_pkg::CMD_TICK, 63'd10);
      send_command(ftp_pkg::CMD_TICK, 63'd20);

      set_rates(REG_ALL_ONES, REG_ALL_ONES);
      send_command(ftp_pkg::CMD_RESET, 63'd0);
      send_command(ftp_pkg::CMD_TICK, 63'h0000_0100_0000_0000);
      send_command(ftp_pkg::CMD_TICK, 63'h4000_0000_0000_0000);
      send_command(ftp_pkg::CMD_TICK, ftp_pkg::TIME_MAX);

      set_rates(ftp_pkg::TPS_RESET, ftp_pkg::MAX_DELTA_RESET);
      run_timeline(PHASE_WORDS, 400);
      set_rates($urandom_range(50, 5000), $urandom_range(10, 2000));
      run_timeline(PHASE_WORDS, 3000);
      set_rates(32'd1, 32'd1);
      steady = 1'b1;
      run_timeline(PHASE_WORDS, 4);
      steady = 1'b0;
      set_rates($urandom, $urandom);
      run_timeline(PHASE_WORDS, 32'hFFFF_FFFF);
      set_rates('0, $urandom_range(0, 100));
      run_timeline(PHASE_WORDS, 200);
      set_rates(REG_ALL_ONES, REG_ALL_ONES);
      run_timeline(PHASE_WORDS, 32'hFFFF_FFFF);

      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("** frame_timer_with_pause: PASSED **");
      end else begin
         $display("** frame_timer_with_pause: FAILED **");
      end
      $finish;
   end

endmodule

FILE: files.f
sv/ftp_pkg.sv
sv/ftp_core.sv
sv/ftp_total.sv
sv/frame_timer_with_pause.sv
sv/ftp_checker.sv
test/frame_timer_checker.sv
test/testbench.sv
